// ===== rtl/core/ols_pkg.sv =====
// Shared types and codes for the ordered list block.
// No dependencies; imported by ols_cell and ordered_list_insert_delete.
`default_nettype none

package ols_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;

    typedef logic [DATA_W-1:0]  t_data;
    typedef logic [1:0]         t_action;
    typedef logic [1:0]         t_status;
    typedef logic [COUNT_W-1:0] t_count;

    localparam t_action ACT_TAIL = 2'd0;
    localparam t_action ACT_HEAD = 2'd1;
    localparam t_action ACT_DEL  = 2'd2;

    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_FULL    = 2'd1;
    localparam t_status ST_MISSING = 2'd2;

    // Broadcast controls for the row of cells, valid for one cycle.
    typedef struct packed {
        logic shift_head;   // every cell takes its left neighbor's entry
        logic load_tail;    // the first free cell takes the new value
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/core/ols_cell.sv =====
// One list cell: holds a single entry and takes part in head shifts,
// tail loads and the delete wavefront. Depends on ols_pkg.
`default_nettype none

module ols_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire ols_pkg::t_cell_ctl i_ctl,
    input  wire ols_pkg::t_data     i_value,
    input  wire ols_pkg::t_data     i_key,
    input  wire ols_pkg::t_data     i_left,
    input  wire ols_pkg::t_data     i_right,
    input  wire logic               i_valid,
    input  wire logic               i_valid_next,
    input  wire logic               i_tail_slot,
    input  wire logic               i_tok,
    input  wire logic               i_carry,
    output      ols_pkg::t_data     o_data,
    output      logic               o_tok,
    output      logic               o_carry,
    output      logic               o_done,
    output      logic               o_found
);
    import ols_pkg::*;

    t_data r_data;
    logic  r_tok;
    logic  r_carry;
    logic  w_hit;
    logic  w_carry;

    // a match here or anywhere nearer the head pulls the right neighbor in
    assign w_hit   = i_valid && (r_data == i_key);
    assign w_carry = i_carry || w_hit;

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.shift_head) begin
            r_data <= i_left;
        end else if (i_ctl.load_tail && i_tail_slot) begin
            r_data <= i_value;
        end else if (i_tok && w_carry) begin
            r_data <= i_right;
        end else begin
            r_data <= r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok   <= 1'b0;
            r_carry <= 1'b0;
        end else begin
            r_tok   <= i_tok && i_valid_next;
            r_carry <= i_tok && w_carry;
        end
    end

    assign o_data  = r_data;
    assign o_tok   = r_tok;
    assign o_carry = r_carry;
    // wavefront stops at the last occupied cell
    assign o_done  = i_tok && !i_valid_next;
    assign o_found = w_carry;

endmodule

`default_nettype wire

// ===== rtl/core/ordered_list_insert_delete.sv =====
// Top level of the bounded ordered list: control, occupancy and the row of cells.
// Depends on ols_pkg and ols_cell.
//
// Usage:
//   A transaction is accepted on a rising edge with start high and busy low;
//   i_action and i_value are sampled there. Each transaction gives exactly one
//   result, shown on o_status and o_entry_count for one cycle with o_valid high.
//   Insert at tail, insert at head, an unused action and a delete from an
//   empty list finish directly: o_valid rises on the next edge and busy
//   stays low, so these can be issued every cycle.
//   A delete sends a wavefront down the row of cells, one cell per cycle,
//   from the head to the last occupied cell; each cell compares its entry to
//   the key and, from the matching cell on, takes its right neighbor's
//   entry. The result is registered once the wavefront reaches the last
//   occupied cell, and busy is high until the edge that raises o_valid.
//   Reset (i_rst_n low, synchronous) empties the list; entry storage is not
//   cleared and needs no clearing pass. The receiver cannot stall: each
//   result is taken in the cycle it is shown.
`default_nettype none

module ordered_list_insert_delete #(
    parameter int CAPACITY = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output      logic             busy,
    input  wire ols_pkg::t_action i_action,
    input  wire ols_pkg::t_data   i_value,
    output      logic             o_valid,
    output      ols_pkg::t_status o_status,
    output      ols_pkg::t_count  o_entry_count
);
    import ols_pkg::*;

    localparam int OCC_W = $clog2(CAPACITY + 1);

    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;
    logic             r_busy;
    logic             n_busy;
    logic             r_start;
    logic             n_start;
    logic             r_valid;
    logic             n_valid;
    t_status          r_status;
    t_status          n_status;
    t_data            r_key;

    logic             w_accept;
    logic             w_full;
    logic             w_done_any;
    logic             w_found_any;
    t_cell_ctl        w_ctl;

    t_data            w_data [CAPACITY];
    logic [CAPACITY-1:0] w_tok_in;
    logic [CAPACITY-1:0] w_carry_in;
    logic [CAPACITY-1:0] w_tok_out;
    logic [CAPACITY-1:0] w_carry_out;
    logic [CAPACITY-1:0] w_done;
    logic [CAPACITY-1:0] w_found;
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_valid_next;
    logic [CAPACITY-1:0] w_tail_slot;

    assign w_accept = start && !r_busy;
    assign w_full   = (r_occ == OCC_W'(CAPACITY));

    assign w_ctl.shift_head = w_accept && (i_action == ACT_HEAD) && !w_full;
    assign w_ctl.load_tail  = w_accept && (i_action == ACT_TAIL) && !w_full;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        t_data w_left;
        t_data w_right;

        assign w_valid[k]      = OCC_W'(k) < r_occ;
        assign w_valid_next[k] = OCC_W'(k + 1) < r_occ;
        assign w_tail_slot[k]  = OCC_W'(k) == r_occ;

        if (k == 0) begin : g_head
            assign w_left        = i_value;
            assign w_tok_in[k]   = r_start;
            assign w_carry_in[k] = 1'b0;
        end else begin : g_body
            assign w_left        = w_data[k-1];
            assign w_tok_in[k]   = w_tok_out[k-1];
            assign w_carry_in[k] = w_carry_out[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign w_right = w_data[k];
        end else begin : g_inner
            assign w_right = w_data[k+1];
        end

        ols_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_value      (i_value),
            .i_key        (r_key),
            .i_left       (w_left),
            .i_right      (w_right),
            .i_valid      (w_valid[k]),
            .i_valid_next (w_valid_next[k]),
            .i_tail_slot  (w_tail_slot[k]),
            .i_tok        (w_tok_in[k]),
            .i_carry      (w_carry_in[k]),
            .o_data       (w_data[k]),
            .o_tok        (w_tok_out[k]),
            .o_carry      (w_carry_out[k]),
            .o_done       (w_done[k]),
            .o_found      (w_found[k])
        );
    end

    assign w_done_any  = |w_done;
    assign w_found_any = |(w_done & w_found);

    always_comb begin
        n_occ    = r_occ;
        n_busy   = r_busy;
        n_start  = 1'b0;
        n_valid  = 1'b0;
        n_status = r_status;
        if (w_accept) begin
            unique case (i_action)
                ACT_TAIL, ACT_HEAD: begin
                    n_valid = 1'b1;
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_status = ST_OK;
                        n_occ    = r_occ + OCC_W'(1);
                    end
                end
                ACT_DEL: begin
                    if (r_occ == '0) begin
                        n_valid  = 1'b1;
                        n_status = ST_MISSING;
                    end else begin
                        n_busy  = 1'b1;
                        n_start = 1'b1;
                    end
                end
                default: begin
                    n_valid  = 1'b1;
                    n_status = ST_OK;
                end
            endcase
        end else if (r_busy && w_done_any) begin
            n_busy   = 1'b0;
            n_valid  = 1'b1;
            n_status = w_found_any ? ST_OK : ST_MISSING;
            if (w_found_any) begin
                n_occ = r_occ - OCC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= '0;
            r_busy  <= 1'b0;
            r_start <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_occ   <= n_occ;
            r_busy  <= n_busy;
            r_start <= n_start;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (w_accept) begin
            r_key <= i_value;
        end
    end

    assign busy          = r_busy;
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_entry_count = COUNT_W'(r_occ);

`ifndef NO_ASSERTIONS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_in))
        else $error("more than one delete wavefront in the row");

    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (|w_tok_in) |-> r_busy)
        else $error("wavefront active while idle");

    a_quiet_wave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !w_done_any) |=> !r_valid)
        else $error("result shown before delete finished");

    a_fast_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_action == ACT_TAIL || i_action == ACT_HEAD)) |=> r_valid)
        else $error("insert transaction gave no result");
`endif

endmodule

`default_nettype wire
